FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SAE_ASSERT(lbl, clk_i, rstn_i, prop) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) \
        else $error("assertion failed");

`define SAE_ASSERT_NEVER(lbl, clk_i, rstn_i, expr) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(expr)) \
        else $error("forbidden condition seen");

`else

`define SAE_ASSERT(lbl, clk_i, rstn_i, prop)

`define SAE_ASSERT_NEVER(lbl, clk_i, rstn_i, expr)

`endif

`endif

FILE: rtl/core/sae_pkg.sv
// Shared types and constants of the six-axis event aggregator.
`default_nettype none

package sae_pkg;

    localparam int NUM_BUTTONS_DEF    = 24;
    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF    = 4;
    localparam int BUTTON_BASE        = 256;
    localparam int AXES               = 6;
    localparam int PADDR_W            = 3;

    localparam logic [14:0] DEAD_ZONE_RST = 15'd2;
    localparam logic [15:0] GAIN_RST      = 16'd256;

    // event types
    localparam logic [1:0] EVT_SYNC  = 2'd0;
    localparam logic [1:0] EVT_KEY   = 2'd1;
    localparam logic [1:0] EVT_REL   = 2'd2;
    localparam logic [1:0] EVT_OTHER = 2'd3;

    // report kinds
    localparam logic [1:0] RPT_MOTION  = 2'd0;
    localparam logic [1:0] RPT_PRESS   = 2'd1;
    localparam logic [1:0] RPT_RELEASE = 2'd2;

    // register word index (paddr[2])
    localparam logic REG_DEAD_ZONE = 1'b0;
    localparam logic REG_GAIN      = 1'b1;

    // usec/1000 as (x * RECIP_1000) >> RECIP_SHIFT, exact for x < 2^20
    localparam int          RECIP_SHIFT = 30;
    localparam logic [20:0] RECIP_1000  = 21'd1073742;

    typedef enum logic [1:0] {
        OP_AXIS,
        OP_KEY,
        OP_SYNC
    } sae_op_kind_t;

    typedef struct packed {
        sae_op_kind_t      kind;
        logic [2:0]        slot;
        logic signed [15:0] value;
        logic [4:0]        button;
        logic              pressed;
        logic [31:0]       sec;
        logic [19:0]       usec;
    } sae_op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sae_qstat_t;

endpackage

`default_nettype wire

FILE: rtl/core/sae_if.sv
// Event and report channel interfaces.
`default_nettype none

interface sae_event_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_type;
    logic [9:0]         event_code;
    logic signed [15:0] event_value;
    logic [31:0]        time_sec;
    logic [19:0]        time_usec;

    modport source (
        output valid, event_type, event_code, event_value, time_sec, time_usec,
        input  ready
    );
    modport sink (
        input  valid, event_type, event_code, event_value, time_sec, time_usec,
        output ready
    );
endinterface

interface sae_report_if;
    logic               valid;
    logic               ready;
    logic [1:0]         report_kind;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] axis_rx;
    logic signed [15:0] axis_ry;
    logic signed [15:0] axis_rz;
    logic [15:0]        period_ms;
    logic [4:0]         button_index;

    modport source (
        output valid, report_kind, axis_x, axis_y, axis_z, axis_rx, axis_ry, axis_rz,
               period_ms, button_index,
        input  ready
    );
    modport sink (
        input  valid, report_kind, axis_x, axis_y, axis_z, axis_rx, axis_ry, axis_rz,
               period_ms, button_index,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/sae_front.sv
// Front end: accepts events, filters them and scales axis moves.
`default_nettype none

module sae_front #(
    parameter int NUM_BUTTONS    = sae_pkg::NUM_BUTTONS_DEF,
    parameter int GAIN_FRAC_BITS = sae_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    sae_event_if.sink          events,
    input  logic [14:0]        dead_zone,
    input  logic [15:0]        gain,
    input  sae_pkg::sae_qstat_t qstat,
    output logic               push,
    output sae_pkg::sae_op_t   push_op
);
    import sae_pkg::*;

    localparam logic [10:0] BTN_END   = 11'(BUTTON_BASE + NUM_BUTTONS);
    localparam logic [9:0]  BTN_FIRST = 10'(BUTTON_BASE);
    localparam logic [9:0]  AXIS_LAST = 10'd5;

    logic          adv;
    logic [15:0]   mag;
    logic          rel_ok;
    logic          key_ok;
    logic          keep;
    sae_op_kind_t  kind;
    logic [2:0]    slot;
    logic          swap;

    // stage 1: decoded item
    logic          s1_valid_reg;
    sae_op_kind_t  s1_kind_reg;
    logic [2:0]    s1_slot_reg;
    logic          s1_neg_reg;
    logic          s1_swap_reg;
    logic [15:0]   s1_mag_reg;
    logic [4:0]    s1_button_reg;
    logic          s1_pressed_reg;
    logic [31:0]   s1_sec_reg;
    logic [19:0]   s1_usec_reg;

    // stage 2: gain product
    logic          s2_valid_reg;
    sae_op_kind_t  s2_kind_reg;
    logic [2:0]    s2_slot_reg;
    logic          s2_neg_reg;
    logic          s2_swap_reg;
    logic [31:0]   s2_prod_reg;
    logic [4:0]    s2_button_reg;
    logic          s2_pressed_reg;
    logic [31:0]   s2_sec_reg;
    logic [19:0]   s2_usec_reg;

    logic [31:0]        scaled;
    logic signed [15:0] sat_value;

    assign adv          = !s2_valid_reg || !qstat.full;
    assign events.ready = adv;

    assign mag    = events.event_value[15] ? (~events.event_value + 16'd1)
                                           : events.event_value;
    assign rel_ok = (events.event_code <= AXIS_LAST) && (mag >= {1'b0, dead_zone});
    assign key_ok = (events.event_code >= BTN_FIRST) && ({1'b0, events.event_code} < BTN_END);

    always_comb
    begin
        slot = events.event_code[2:0];
        swap = 1'b0;
        unique case (events.event_code[2:0])
            3'd1:
            begin
                slot = 3'd2;
                swap = 1'b1;
            end
            3'd2:
            begin
                slot = 3'd1;
                swap = 1'b1;
            end
            3'd4:
            begin
                slot = 3'd5;
                swap = 1'b1;
            end
            3'd5:
            begin
                slot = 3'd4;
                swap = 1'b1;
            end
            default:
            begin
                slot = events.event_code[2:0];
                swap = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        keep = 1'b0;
        kind = OP_SYNC;
        unique case (events.event_type)
            EVT_SYNC:
            begin
                keep = 1'b1;
                kind = OP_SYNC;
            end
            EVT_KEY:
            begin
                keep = key_ok;
                kind = OP_KEY;
            end
            EVT_REL:
            begin
                keep = rel_ok;
                kind = OP_AXIS;
            end
            EVT_OTHER:
            begin
                keep = 1'b0;
                kind = OP_SYNC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= events.valid && keep;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg    <= kind;
            s1_slot_reg    <= slot;
            // a swapped axis is negated, so the output sign flips
            s1_neg_reg     <= events.event_value[15] ^ swap;
            s1_swap_reg    <= swap;
            s1_mag_reg     <= mag;
            s1_button_reg  <= 5'(events.event_code - BTN_FIRST);
            s1_pressed_reg <= (events.event_value != 16'sd0);
            s1_sec_reg     <= events.time_sec;
            s1_usec_reg    <= events.time_usec;

            s2_kind_reg    <= s1_kind_reg;
            s2_slot_reg    <= s1_slot_reg;
            s2_neg_reg     <= s1_neg_reg;
            s2_swap_reg    <= s1_swap_reg;
            s2_prod_reg    <= 32'(s1_mag_reg) * 32'(gain);
            s2_button_reg  <= s1_button_reg;
            s2_pressed_reg <= s1_pressed_reg;
            s2_sec_reg     <= s1_sec_reg;
            s2_usec_reg    <= s1_usec_reg;
        end
    end

    assign scaled = s2_prod_reg >> GAIN_FRAC_BITS;

    // positive results clamp at 32767; negative ones at -32768, or at -32767
    // when a positive move was clamped before the swap negated it
    always_comb
    begin
        if (s2_neg_reg)
            sat_value = (scaled >= 32'd32768) ? (s2_swap_reg ? 16'sh8001 : 16'sh8000)
                                              : -$signed(scaled[15:0]);
        else
            sat_value = (scaled > 32'd32767) ? 16'sh7fff : $signed(scaled[15:0]);
    end

    assign push            = s2_valid_reg && !qstat.full;
    assign push_op.kind    = s2_kind_reg;
    assign push_op.slot    = s2_slot_reg;
    assign push_op.value   = sat_value;
    assign push_op.button  = s2_button_reg;
    assign push_op.pressed = s2_pressed_reg;
    assign push_op.sec     = s2_sec_reg;
    assign push_op.usec    = s2_usec_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sae_queue.sv
// Short FIFO of classified items between front and back end.
`default_nettype none

module sae_queue #(
    parameter int DEPTH = sae_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sae_pkg::sae_op_t    push_op,
    input  logic                pop,
    output sae_pkg::sae_op_t    pop_op,
    output sae_pkg::sae_qstat_t qstat
);
    import sae_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sae_op_t            entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign qstat.full  = (count_reg == CNT_FULL);
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign pop_op      = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_op;
    end

endmodule

`default_nettype wire

FILE: rtl/core/sae_back.sv
// Back end: applies items to the axis store and builds reports.
`default_nettype none

module sae_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sae_pkg::sae_qstat_t qstat,
    output logic                pop,
    input  sae_pkg::sae_op_t    pop_op,
    sae_report_if.source        reports
);
    import sae_pkg::*;

    localparam logic signed [32:0] DS_HI   = 33'sd67;
    localparam logic signed [32:0] DS_LO   = -33'sd2;
    localparam logic signed [17:0] MS_MULT = 18'sd1000;

    logic adv;
    logic fire;

    // architectural state
    logic signed [15:0] axis_store_reg [AXES];
    logic               pending_reg;
    logic               last_was_key_reg;
    logic [4:0]         last_button_reg;
    logic               last_pressed_reg;
    logic [31:0]        last_sec_reg;
    logic [19:0]        last_usec_reg;
    logic [31:0]        motion_sec_reg;
    logic [19:0]        motion_usec_reg;

    // report pipeline
    logic               s1_valid_reg;
    logic               s1_key_reg;
    logic [1:0]         s1_kind_reg;
    logic [4:0]         s1_button_reg;
    logic signed [15:0] s1_axes_reg [AXES];
    logic [31:0]        s1_lsec_reg;
    logic [19:0]        s1_lusec_reg;
    logic [31:0]        s1_msec_reg;
    logic [19:0]        s1_musec_reg;

    logic               s2_valid_reg;
    logic               s2_key_reg;
    logic [1:0]         s2_kind_reg;
    logic [4:0]         s2_button_reg;
    logic signed [15:0] s2_axes_reg [AXES];
    logic signed [7:0]  s2_ds_reg;
    logic [19:0]        s2_dumag_reg;
    logic               s2_dneg_reg;

    logic               s3_valid_reg;
    logic               s3_key_reg;
    logic [1:0]         s3_kind_reg;
    logic [4:0]         s3_button_reg;
    logic signed [15:0] s3_axes_reg [AXES];
    logic signed [17:0] s3_dsms_reg;
    logic [10:0]        s3_q_reg;
    logic               s3_dneg_reg;

    logic               out_valid_reg;
    logic [1:0]         out_kind_reg;
    logic [4:0]         out_button_reg;
    logic signed [15:0] out_axes_reg [AXES];
    logic [15:0]        out_period_reg;

    logic signed [32:0] ds;
    logic signed [7:0]  ds_clamp;
    logic signed [20:0] du;
    logic [19:0]        du_mag;
    logic [40:0]        q_prod;
    logic signed [18:0] q_s;
    logic signed [18:0] ms;
    logic [15:0]        period;

    assign adv  = !out_valid_reg || reports.ready;
    assign pop  = adv && !qstat.empty;
    assign fire = pop && (pop_op.kind == OP_SYNC) && pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
                axis_store_reg[i] <= '0;
            pending_reg      <= 1'b0;
            last_was_key_reg <= 1'b0;
            last_button_reg  <= '0;
            last_pressed_reg <= 1'b0;
            last_sec_reg     <= '0;
            last_usec_reg    <= '0;
            motion_sec_reg   <= '0;
            motion_usec_reg  <= '0;
        end
        else if (pop)
        begin
            unique case (pop_op.kind)
                OP_AXIS:
                begin
                    axis_store_reg[pop_op.slot] <= pop_op.value;
                    last_was_key_reg <= 1'b0;
                    last_sec_reg     <= pop_op.sec;
                    last_usec_reg    <= pop_op.usec;
                    pending_reg      <= 1'b1;
                end
                OP_KEY:
                begin
                    last_button_reg  <= pop_op.button;
                    last_pressed_reg <= pop_op.pressed;
                    last_was_key_reg <= 1'b1;
                    last_sec_reg     <= pop_op.sec;
                    last_usec_reg    <= pop_op.usec;
                    pending_reg      <= 1'b1;
                end
                OP_SYNC:
                begin
                    if (pending_reg)
                    begin
                        pending_reg <= 1'b0;
                        if (!last_was_key_reg)
                        begin
                            motion_sec_reg  <= last_sec_reg;
                            motion_usec_reg <= last_usec_reg;
                        end
                    end
                end
                default:
                begin
                    pending_reg <= pending_reg;
                end
            endcase
        end
    end

    // period = ds*1000 + du/1000; ds is clamped where the result saturates anyway
    assign ds = $signed({1'b0, s1_lsec_reg}) - $signed({1'b0, s1_msec_reg});
    assign du = $signed({1'b0, s1_lusec_reg}) - $signed({1'b0, s1_musec_reg});

    always_comb
    begin
        if (ds > DS_HI)
            ds_clamp = 8'sd67;
        else if (ds < DS_LO)
            ds_clamp = -8'sd2;
        else
            ds_clamp = ds[7:0];
    end

    assign du_mag = du[20] ? 20'(-du) : du[19:0];
    assign q_prod = 41'(s2_dumag_reg) * 41'(RECIP_1000);
    assign q_s    = $signed({8'd0, s3_q_reg});
    assign ms     = 19'(s3_dsms_reg) + (s3_dneg_reg ? -q_s : q_s);

    always_comb
    begin
        if (ms < 19'sd0)
            period = 16'd0;
        else if (ms > 19'sd65535)
            period = 16'hffff;
        else
            period = ms[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= fire;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_key_reg    <= last_was_key_reg;
            s1_kind_reg   <= !last_was_key_reg ? RPT_MOTION
                           : (last_pressed_reg ? RPT_PRESS : RPT_RELEASE);
            s1_button_reg <= last_was_key_reg ? last_button_reg : 5'd0;
            for (int i = 0; i < AXES; i++)
                s1_axes_reg[i] <= last_was_key_reg ? 16'sd0 : axis_store_reg[i];
            s1_lsec_reg   <= last_sec_reg;
            s1_lusec_reg  <= last_usec_reg;
            s1_msec_reg   <= motion_sec_reg;
            s1_musec_reg  <= motion_usec_reg;

            s2_key_reg    <= s1_key_reg;
            s2_kind_reg   <= s1_kind_reg;
            s2_button_reg <= s1_button_reg;
            s2_axes_reg   <= s1_axes_reg;
            s2_ds_reg     <= ds_clamp;
            s2_dumag_reg  <= du_mag;
            s2_dneg_reg   <= du[20];

            s3_key_reg    <= s2_key_reg;
            s3_kind_reg   <= s2_kind_reg;
            s3_button_reg <= s2_button_reg;
            s3_axes_reg   <= s2_axes_reg;
            s3_dsms_reg   <= 18'(s2_ds_reg) * MS_MULT;
            s3_q_reg      <= 11'(q_prod >> RECIP_SHIFT);
            s3_dneg_reg   <= s2_dneg_reg;

            out_kind_reg   <= s3_kind_reg;
            out_button_reg <= s3_button_reg;
            out_axes_reg   <= s3_axes_reg;
            out_period_reg <= s3_key_reg ? 16'd0 : period;
        end
    end

    assign reports.valid        = out_valid_reg;
    assign reports.report_kind  = out_kind_reg;
    assign reports.axis_x       = out_axes_reg[0];
    assign reports.axis_y       = out_axes_reg[1];
    assign reports.axis_z       = out_axes_reg[2];
    assign reports.axis_rx      = out_axes_reg[3];
    assign reports.axis_ry      = out_axes_reg[4];
    assign reports.axis_rz      = out_axes_reg[5];
    assign reports.period_ms    = out_period_reg;
    assign reports.button_index = out_button_reg;

endmodule

`default_nettype wire

FILE: rtl/core/six_axis_event_aggregator.sv
// Top level of the six-axis event aggregator: config registers and the datapath.
//
//  channel   dir   handshake        payload
//  events    in    valid/ready      event_type, event_code, event_value, time_sec, time_usec
//  reports   out   valid/ready      report_kind, six axes, period_ms, button_index
//  apb       in    psel/penable     paddr, pwdata, prdata (pready tied high)
//
// One item per cycle sustained while reports are not stalled; the gain multiply and the usec/1000
// reciprocal multiply each own a pipeline stage.
// Path from event to report: 2 front stages, the queue, then 4 back stages.
// Reset is asynchronous and clears all control and axis state at once.
// A stalled report holds the output register; the 4-entry queue and the
// front stages keep accepting items until the queue fills.
`default_nettype none

`include "assert_macros.svh"

module six_axis_event_aggregator #(
    parameter int NUM_BUTTONS    = sae_pkg::NUM_BUTTONS_DEF,
    parameter int GAIN_FRAC_BITS = sae_pkg::GAIN_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH    = sae_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sae_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    sae_event_if.sink                   events,
    sae_report_if.source                reports
);
    import sae_pkg::*;

    logic [14:0] dead_zone_reg;
    logic [15:0] gain_reg;
    logic        cfg_wr;
    logic        reg_idx;

    sae_qstat_t  qstat;
    logic        push;
    sae_op_t     push_op;
    logic        pop;
    sae_op_t     pop_op;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= DEAD_ZONE_RST;
            gain_reg      <= GAIN_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_DEAD_ZONE: dead_zone_reg <= pwdata[14:0];
                REG_GAIN:      gain_reg      <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DEAD_ZONE: prdata = {17'd0, dead_zone_reg};
            REG_GAIN:      prdata = {16'd0, gain_reg};
        endcase
    end

    sae_front #(
        .NUM_BUTTONS    (NUM_BUTTONS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .events    (events),
        .dead_zone (dead_zone_reg),
        .gain      (gain_reg),
        .qstat     (qstat),
        .push      (push),
        .push_op   (push_op)
    );

    sae_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .pop_op  (pop_op),
        .qstat   (qstat)
    );

    sae_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .qstat   (qstat),
        .pop     (pop),
        .pop_op  (pop_op),
        .reports (reports)
    );

    `SAE_ASSERT_NEVER(a_queue_no_overflow, clk, rst_n, push && qstat.full)
    `SAE_ASSERT(a_motion_no_button, clk, rst_n, (reports.valid && (reports.report_kind == RPT_MOTION)) |-> (reports.button_index == 5'd0))
    `SAE_ASSERT(a_button_no_motion, clk, rst_n, (reports.valid && (reports.report_kind != RPT_MOTION)) |-> ((reports.period_ms == 16'd0) && (reports.axis_x == 16'sd0) && (reports.axis_rz == 16'sd0)))
    `SAE_ASSERT_NEVER(a_kind_valid, clk, rst_n, reports.valid && (reports.report_kind != RPT_MOTION) && (reports.report_kind != RPT_PRESS) && (reports.report_kind != RPT_RELEASE))

endmodule

`default_nettype wire
